@@ rtl/core/assert_macros.svh @@
// Assertion helpers, all sampled on the rising edge of clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle or overlapping implication.
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next cycle.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/deq_pkg.sv @@
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int VALUE_W = 32;
    localparam int OPC_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ rtl/core/deq_in_if.sv @@
interface deq_in_if;
    logic                                valid;
    logic                                ready;
    logic        [deq_pkg::OPC_W-1:0]    operation;
    logic signed [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ rtl/core/deq_out_if.sv @@
interface deq_out_if;
    logic                                valid;
    logic                                ready;
    logic        [deq_pkg::STAT_W-1:0]   status;
    logic signed [deq_pkg::VALUE_W-1:0]  front_value;
    logic signed [deq_pkg::VALUE_W-1:0]  back_value;
    logic        [deq_pkg::COUNT_W-1:0]  entry_count;
    logic                                is_empty;

    modport source (output valid, output status, output front_value, output back_value,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input status, input front_value, input back_value,
                    input entry_count, input is_empty, output ready);
endinterface

@@ rtl/core/double_ended_queue.sv @@
// channel   dir   word contents
// --------  ----  ---------------------------------------------------------
// in_ch     in    operation (push/pop, front/back), value
// out_ch    out   status, front_value, back_value, entry_count, is_empty
//
// An item is accepted in S_IDLE, where the edge writes the entry store or
// issues its read, and finished in S_BUSY, where an edge loads the result into
// the output register. The store's read port is registered (rd_data_reg).
// The output register holds a result while the next word is accepted; the
// S_BUSY step of that word waits only while out_ch is still stalled.
// rst_n is asynchronous: head, count, FSM and output valid clear at once.
module double_ended_queue
(
    input  logic       clk,
    input  logic       rst_n,
    deq_in_if.sink     in_ch,
    deq_out_if.source  out_ch
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } state_t;

    // Entry store: one write port, one registered read port.
    logic signed [deq_pkg::DATA_WIDTH-1:0] entry_mem [deq_pkg::DEPTH];
    logic signed [deq_pkg::DATA_WIDTH-1:0] rd_data_reg;

    state_t                         state_reg, state_next;
    logic [deq_pkg::IDX_W-1:0]      head_reg, head_next;
    logic [deq_pkg::CNT_W-1:0]      count_reg, count_next;

    // Cached front and back entries, only meaningful while count is nonzero.
    logic signed [deq_pkg::DATA_WIDTH-1:0] front_reg, front_next;
    logic signed [deq_pkg::DATA_WIDTH-1:0] back_reg, back_next;

    // The word in flight between accept and result.
    deq_pkg::op_t                   pend_op_reg;
    deq_pkg::status_t               pend_status_reg;
    logic signed [deq_pkg::DATA_WIDTH-1:0] pend_value_reg;

    logic                           out_valid_reg;
    deq_pkg::status_t               out_status_reg;
    logic signed [deq_pkg::VALUE_W-1:0]    out_front_reg;
    logic signed [deq_pkg::VALUE_W-1:0]    out_back_reg;
    logic [deq_pkg::COUNT_W-1:0]    out_count_reg;
    logic                           out_empty_reg;

    deq_pkg::op_t                   op;
    deq_pkg::status_t               acc_status;
    logic                           in_acc;
    logic                           done;
    logic                           is_full;
    logic                           is_emp;
    logic [deq_pkg::IDX_W-1:0]      head_inc;
    logic [deq_pkg::IDX_W-1:0]      head_dec;
    logic [deq_pkg::SUM_W-1:0]      tail_sum;
    logic [deq_pkg::SUM_W-1:0]      pop_sum;
    logic [deq_pkg::IDX_W-1:0]      push_tail;
    logic [deq_pkg::IDX_W-1:0]      pop_tail;
    logic                           wr_en;
    logic [deq_pkg::IDX_W-1:0]      wr_addr;
    logic                           rd_en;
    logic [deq_pkg::IDX_W-1:0]      rd_addr;
    logic signed [deq_pkg::DATA_WIDTH-1:0] in_data;

    assign op      = deq_pkg::op_t'(in_ch.operation);
    assign in_data = deq_pkg::DATA_WIDTH'(in_ch.value);
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc  = in_ch.valid && in_ch.ready;
    // Result can move into the output register once it is free or draining.
    assign done    = (state_reg == S_BUSY) && (!out_valid_reg || out_ch.ready);

    assign is_full = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_emp  = (count_reg == '0);

    // Ring index arithmetic, one compare-and-subtract per wrap.
    assign head_inc = (head_reg == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0
                                                                      : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
                                       : head_reg - 1'b1;
    assign tail_sum = {1'b0, head_reg} + deq_pkg::SUM_W'(count_reg);
    assign pop_sum  = tail_sum - deq_pkg::SUM_W'(2);
    assign push_tail = (tail_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     ? deq_pkg::IDX_W'(tail_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     : deq_pkg::IDX_W'(tail_sum);
    assign pop_tail  = (pop_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     ? deq_pkg::IDX_W'(pop_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                     : deq_pkg::IDX_W'(pop_sum);

    // Accept side: update head/count, write the store or fetch the new end.
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        acc_status = deq_pkg::ST_OK;
        wr_en      = 1'b0;
        wr_addr    = head_dec;
        rd_en      = 1'b0;
        rd_addr    = head_inc;
        case (op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    acc_status = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    acc_status = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = push_tail;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_emp)
                begin
                    acc_status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    rd_en      = (count_reg > deq_pkg::CNT_W'(1));
                    rd_addr    = head_inc;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_emp)
                begin
                    acc_status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    rd_en      = (count_reg > deq_pkg::CNT_W'(1));
                    rd_addr    = pop_tail;
                end
            end
            default:
            begin
                acc_status = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && wr_en)
        begin
            entry_mem[wr_addr] <= in_data;
        end
        if (in_acc && rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    // Result side: count_reg already holds the count after the word.
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        if (pend_status_reg == deq_pkg::ST_OK)
        begin
            case (pend_op_reg)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    front_next = pend_value_reg;
                    if (count_reg == deq_pkg::CNT_W'(1))
                    begin
                        back_next = pend_value_reg;
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    back_next = pend_value_reg;
                    if (count_reg == deq_pkg::CNT_W'(1))
                    begin
                        front_next = pend_value_reg;
                    end
                end
                deq_pkg::OP_POP_FRONT: front_next = rd_data_reg;
                deq_pkg::OP_POP_BACK:  back_next  = rd_data_reg;
                default:               front_next = front_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_BUSY;
            S_BUSY: if (done)   state_next = S_IDLE;
            default:            state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pend_op_reg     <= op;
            pend_status_reg <= acc_status;
            pend_value_reg  <= in_data;
        end
        if (done)
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= deq_pkg::COUNT_W'(count_reg);
            out_empty_reg  <= (count_reg == '0);
            out_front_reg  <= (count_reg == '0) ? '0 : deq_pkg::VALUE_W'(front_next);
            out_back_reg   <= (count_reg == '0) ? '0 : deq_pkg::VALUE_W'(back_next);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.front_value = out_front_reg;
    assign out_ch.back_value  = out_back_reg;
    assign out_ch.entry_count = out_count_reg;
    assign out_ch.is_empty    = out_empty_reg;

endmodule

@@ rtl/core/deq_checker.sv @@
`include "assert_macros.svh"

module deq_port_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [deq_pkg::STAT_W-1:0]     status,
    input logic [deq_pkg::VALUE_W-1:0]    front_value,
    input logic [deq_pkg::VALUE_W-1:0]    back_value,
    input logic [deq_pkg::COUNT_W-1:0]    entry_count,
    input logic                           is_empty
);

    logic count_zero;
    logic ends_zero;
    logic empty_pop;
    logic in_take;
    logic out_stall;

    assign count_zero = (entry_count == '0);
    assign ends_zero  = (front_value == '0) && (back_value == '0);
    assign empty_pop  = out_valid && (status == deq_pkg::ST_EMPTY);
    assign in_take    = in_valid && in_ready;
    assign out_stall  = out_valid && !out_ready;

    `DEQ_ASSERT(a_empty_flag, out_valid |-> (is_empty == count_zero), "empty flag and count disagree")
    `DEQ_ASSERT(a_empty_zero, (out_valid && is_empty) |-> ends_zero, "nonzero ends on empty queue")
    `DEQ_ASSERT(a_status_state, empty_pop |-> is_empty, "empty pop left entries")
    `DEQ_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready, "word taken while one is in flight")
    `DEQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(entry_count), "stalled word lost")

endmodule

bind double_ended_queue deq_port_checker u_deq_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .front_value (out_ch.front_value),
    .back_value  (out_ch.back_value),
    .entry_count (out_ch.entry_count),
    .is_empty    (out_ch.is_empty)
);

@@ tb/deq_checker.sv @@
// Watches both channels of the deque, keeps a shadow copy of its contents and
// compares every output word against the view predicted for it.
module deq_checker
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    deq_in_if           in_mon,
    deq_out_if          out_mon,
    output int unsigned fail_count,
    output int unsigned pending
);

    // What the output word should show after one operation.
    typedef struct {
        status_t                    status;
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [VALUE_W-1:0]  back_value;
        logic        [COUNT_W-1:0]  entry_count;
        logic                       is_empty;
    } deq_view_t;

    logic signed [DATA_WIDTH-1:0] shadow_store [DEPTH];
    logic        [IDX_W-1:0]      shadow_head;
    logic        [CNT_W-1:0]      shadow_fill;
    deq_view_t                    expected_views [$];
    int unsigned                  mismatches;

    // Apply one operation to the shadow deque and report the resulting view.
    task automatic apply_deque_op(input op_t op, input logic signed [VALUE_W-1:0] value,
                                  output deq_view_t view);
        logic [IDX_W-1:0] slot;
        view.status = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            if (shadow_fill >= CNT_W'(DEPTH))
                view.status = ST_FULL;
            else if (op == OP_PUSH_FRONT)
            begin
                shadow_head               = shadow_head - 1'b1;
                shadow_store[shadow_head] = value;
                shadow_fill               = shadow_fill + 1'b1;
            end
            else
            begin
                slot               = shadow_head + shadow_fill[IDX_W-1:0];
                shadow_store[slot] = value;
                shadow_fill        = shadow_fill + 1'b1;
            end
        end
        else
        begin
            if (shadow_fill == '0)
                view.status = ST_EMPTY;
            else
            begin
                if (op == OP_POP_FRONT)
                    shadow_head = shadow_head + 1'b1;
                shadow_fill = shadow_fill - 1'b1;
            end
        end
        view.entry_count = COUNT_W'(shadow_fill);
        if (shadow_fill == '0)
        begin
            view.front_value = '0;
            view.back_value  = '0;
            view.is_empty    = 1'b1;
        end
        else
        begin
            // back sits at head + fill - 1, wrapping on the index width
            slot             = shadow_head + shadow_fill[IDX_W-1:0] - 1'b1;
            view.front_value = shadow_store[shadow_head];
            view.back_value  = shadow_store[slot];
            view.is_empty    = 1'b0;
        end
    endtask

    task automatic flag_mismatch(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_view_t want;
        deq_view_t got;
        if (!rst_n)
        begin
            shadow_head = '0;
            shadow_fill = '0;
            expected_views.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare first, so a word that arrives with nothing queued is caught
            if (out_mon.valid && out_mon.ready)
            begin
                got.status      = status_t'(out_mon.status);
                got.front_value = out_mon.front_value;
                got.back_value  = out_mon.back_value;
                got.entry_count = out_mon.entry_count;
                got.is_empty    = out_mon.is_empty;
                if (expected_views.size() == 0)
                begin
                    $display("%0t: unexpected output word, expected none, actual count %0d",
                             $time, got.entry_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", want.status, got.status);
                    if (got.front_value !== want.front_value)
                        flag_mismatch("front_value", want.front_value, got.front_value);
                    if (got.back_value !== want.back_value)
                        flag_mismatch("back_value", want.back_value, got.back_value);
                    if (got.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", want.entry_count, got.entry_count);
                    if (got.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", want.is_empty, got.is_empty);
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                apply_deque_op(op_t'(in_mon.operation), in_mon.value, want);
                expected_views.push_back(want);
            end
            fail_count <= mismatches;
            pending    <= expected_views.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Top of the deque testbench: clock, reset, stimulus on in_ch, random
// back-pressure on out_ch, and the verdict. All prediction and comparison
// lives in deq_checker.
module tb_top;
    import deq_pkg::*;

    localparam int          RANDOM_WORDS = 1700;
    // Worst correct run is roughly 1725 words, each with the longest gap and
    // stall; the limit leaves several times that.
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          SETTLE       = 10;

    logic        clk;
    logic        rst_n;
    int unsigned chk_fails;
    int unsigned chk_pending;
    int unsigned cycle_count = 0;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    double_ended_queue dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    deq_checker u_chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (chk_fails),
        .pending    (chk_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values lean on the sign boundaries, zero and all ones; the rest is random.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Present one word and hold it until the deque takes it. valid stays high
    // on return, so a back-to-back word needs no extra edge.
    task automatic send_word(input op_t op, input logic signed [VALUE_W-1:0] val);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid for an idle gap of length n; n == 0 leaves the channel streaming.
    task automatic idle(input int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off the sender until every predicted word has come out. The first
    // edge lets the checker count the word accepted at this step.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
            @(posedge clk);
    endtask

    // Receiver: each phase is picked at random as always-ready or as one with random stalls.
    initial
    begin
        int stall_left;
        int mode_left;
        bit stalling;
        stall_left = 0;
        mode_left  = 0;
        stalling   = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stalling  = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (stalling && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Hard stop on a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int   sent;
        int   phase_len;
        int   push_pct;
        bit   quiet;
        op_t  op;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_PUSH_FRONT;
        in_ch.value     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // pops on an empty deque, from either end
        send_word(OP_POP_FRONT, 32'sh1234_5678);
        send_word(OP_POP_BACK, -1);
        // both sign extremes, one at each end, then empty it from both ends
        send_word(OP_PUSH_FRONT, 32'sh8000_0000);
        send_word(OP_PUSH_BACK, 32'sh7fff_ffff);
        idle(pick_gap());
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        // fill to the brim from alternating ends; head wraps below zero
        for (int k = 0; k < DEPTH; k++)
        begin
            send_word(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      k[0] ? (32'sh5555_5555 ^ k) : (32'shAAAA_AAAA ^ (k << 8)));
            idle(pick_gap());
        end
        // pushes on a full deque are dropped
        send_word(OP_PUSH_FRONT, 32'sh0bad_0001);
        send_word(OP_PUSH_BACK, 32'sh0bad_0002);
        send_word(OP_POP_FRONT, '0);
        drain_results();

        // --- random part ---
        // Most phases lean toward pushes or pops so the deque swings between
        // empty and full many times; some phases stream with no gaps.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 4))
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 50;
                3:       push_pct = 65;
                default: push_pct = 35;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len && sent < RANDOM_WORDS; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                send_word(op, pick_value());
                sent++;
                idle(quiet ? 0 : pick_gap());
            end
            if ($urandom_range(0, 4) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (chk_fails == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
